// ===== rtl/core/calendar_clock_minute_advance_unit_defines.svh =====
// assertion macros for the calendar clock minute advance unit
// expects clk and rst_n in the scope where a macro is used
`ifndef CALENDAR_CLOCK_MINUTE_ADVANCE_UNIT_DEFINES_SVH
`define CALENDAR_CLOCK_MINUTE_ADVANCE_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define CCMA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar clock check failed");

// consequent checked in the next cycle
`define CCMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar clock check failed");

`endif

// ===== rtl/core/ccma_pkg.sv =====
// shared types, constants and a helper function for the calendar clock
// no dependencies
`default_nettype none

package ccma_pkg;

    localparam int TPM_BITS          = 16;
    localparam int YEAR_BITS         = 16;
    localparam int MONTH_BITS        = 4;
    localparam int DAY_BITS          = 5;
    localparam int HOUR_BITS         = 5;
    localparam int MINUTE_BITS       = 6;
    localparam int YMOD_BITS         = 9;
    localparam int DEFAULT_TICK_BITS = 16;

    // gregorian cycle: year mod 400 decides leap years
    localparam int YEAR_CYCLE   = 400;
    localparam int YMOD_STEPS   = 8;
    localparam int SHIFT_BITS   = 3;
    localparam int CENTURY      = 100;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MONTHS_PER_YEAR  = 12;

    localparam int RESET_YEAR   = 2024;
    localparam int RESET_MONTH  = 1;
    localparam int RESET_DAY    = 1;
    localparam int RESET_HOUR   = 6;
    localparam int RESET_MINUTE = 0;
    localparam int RESET_YMOD   = RESET_YEAR % YEAR_CYCLE;
    localparam int RESET_TPM    = 1;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;

    localparam logic [DAY_BITS-1:0] DAYS_LONG  = 5'd31;
    localparam logic [DAY_BITS-1:0] DAYS_SHORT = 5'd30;
    localparam logic [DAY_BITS-1:0] DAYS_LEAP  = 5'd29;
    localparam logic [DAY_BITS-1:0] DAYS_FEB   = 5'd28;

    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_SET     = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_YMOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0]   year;
        logic [MONTH_BITS-1:0]  month;
        logic [DAY_BITS-1:0]    day;
        logic [HOUR_BITS-1:0]   hour;
        logic [MINUTE_BITS-1:0] minute;
    } cal_t;

    typedef struct packed {
        logic                  in_ready;
        logic                  sel_year;
        logic                  step_en;
        logic                  ymod_en;
        logic                  load_out;
        logic [SHIFT_BITS-1:0] shift;
    } ctrl_t;

    function automatic logic [DAY_BITS-1:0] month_length(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_FEB;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = DAYS_SHORT;
            default:   len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/calendar_clock_minute_advance_unit.sv =====
// advance request: elapsed ticks added to the remainder, then minutes stepped (one per
//   cycle through the shared compare/subtract unit) while the remainder is at least tpm
// set request: 8-step year mod 400 reduction; any next request waits until the result loads
// reset (async, active low): 2024-01-01 06:00, remainder 0, ticks per minute 1
// depends on ccma_pkg, ccma_seq, ccma_sub_unit, ccma_cal_step
`default_nettype none

module calendar_clock_minute_advance_unit #(
    parameter int TICK_BITS = ccma_pkg::DEFAULT_TICK_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [TICK_BITS-1:0]              elapsed_ticks,
    input  wire logic [ccma_pkg::YEAR_BITS-1:0]    set_year,
    input  wire logic [ccma_pkg::MONTH_BITS-1:0]   set_month,
    input  wire logic [ccma_pkg::DAY_BITS-1:0]     set_day,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [ccma_pkg::YEAR_BITS-1:0]    year_now,
    output logic      [ccma_pkg::MONTH_BITS-1:0]   month_now,
    output logic      [ccma_pkg::DAY_BITS-1:0]     day_now,
    output logic      [ccma_pkg::HOUR_BITS-1:0]    hour_now,
    output logic      [ccma_pkg::MINUTE_BITS-1:0]  minute_now,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ccma_pkg::TPM_BITS-1:0]     cfg_data
);

    import ccma_pkg::*;

    // remainder fits in TPM_BITS before an add, so one extra bit holds the sum
    localparam int REM_BITS = ((TICK_BITS > TPM_BITS) ? TICK_BITS : TPM_BITS) + 1;

    ctrl_t                  ctrl;
    logic                   in_fire;
    logic                   out_free;
    logic                   ge;
    logic [REM_BITS-1:0]    unit_a;
    logic [REM_BITS-1:0]    unit_b;
    logic [REM_BITS-1:0]    diff;
    logic [TPM_BITS-1:0]    tpm_eff;

    logic [TPM_BITS-1:0]    tpm_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [REM_BITS-1:0]    rem_next;
    cal_t                   cal_reg;
    cal_t                   cal_next;
    cal_t                   cal_step;
    logic [YEAR_BITS-1:0]   ymod_reg;
    logic [YEAR_BITS-1:0]   ymod_next;
    logic [YMOD_BITS-1:0]   ymod_step;
    cal_t                   out_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    assign in_ready  = ctrl.in_ready;
    assign in_fire   = in_valid && ctrl.in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // zero ticks per minute acts as one
    assign tpm_eff = (tpm_reg == '0) ? TPM_BITS'(1) : tpm_reg;

    assign unit_a = ctrl.sel_year ? REM_BITS'(ymod_reg) : rem_reg;
    assign unit_b = ctrl.sel_year ? (REM_BITS'(YEAR_CYCLE) << ctrl.shift)
                                  : REM_BITS'(tpm_eff);

    ccma_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .command  (command),
        .ge       (ge),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    ccma_sub_unit #(
        .WIDTH (REM_BITS)
    ) u_sub (
        .a    (unit_a),
        .b    (unit_b),
        .diff (diff),
        .ge   (ge)
    );

    ccma_cal_step u_step (
        .cal       (cal_reg),
        .ymod      (ymod_reg[YMOD_BITS-1:0]),
        .cal_next  (cal_step),
        .ymod_next (ymod_step)
    );

    always_comb
    begin
        rem_next  = rem_reg;
        cal_next  = cal_reg;
        ymod_next = ymod_reg;
        if (in_fire)
        begin
            if (command == CMD_SET)
            begin
                cal_next.year   = set_year;
                cal_next.month  = set_month;
                cal_next.day    = set_day;
                cal_next.hour   = HOUR_BITS'(RESET_HOUR);
                cal_next.minute = '0;
                ymod_next       = set_year;
            end
            else
            begin
                rem_next = rem_reg + REM_BITS'(elapsed_ticks);
            end
        end
        else if (ctrl.step_en)
        begin
            rem_next  = diff;
            cal_next  = cal_step;
            ymod_next = YEAR_BITS'(ymod_step);
        end
        else if (ctrl.ymod_en)
        begin
            ymod_next = diff[YEAR_BITS-1:0];
        end
    end

    always_comb
    begin
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg        <= TPM_BITS'(RESET_TPM);
            rem_reg        <= '0;
            cal_reg.year   <= YEAR_BITS'(RESET_YEAR);
            cal_reg.month  <= MONTH_BITS'(RESET_MONTH);
            cal_reg.day    <= DAY_BITS'(RESET_DAY);
            cal_reg.hour   <= HOUR_BITS'(RESET_HOUR);
            cal_reg.minute <= MINUTE_BITS'(RESET_MINUTE);
            ymod_reg       <= YEAR_BITS'(RESET_YMOD);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tpm_reg <= cfg_data;
            end
            rem_reg       <= rem_next;
            cal_reg       <= cal_next;
            ymod_reg      <= ymod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_reg <= cal_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign year_now   = out_reg.year;
    assign month_now  = out_reg.month;
    assign day_now    = out_reg.day;
    assign hour_now   = out_reg.hour;
    assign minute_now = out_reg.minute;

endmodule

`default_nettype wire

// ===== rtl/core/ccma_sub_unit.sv =====
// shared compare and subtract unit: a - b with a >= b flag
// no dependencies
`default_nettype none

module ccma_sub_unit #(
    parameter int WIDTH = 17
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    output logic      [WIDTH-1:0] diff,
    output logic                  ge
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

`default_nettype wire

// ===== rtl/core/ccma_cal_step.sv =====
// one-minute step of the gregorian calendar
// depends on ccma_pkg
`default_nettype none

module ccma_cal_step (
    input  wire ccma_pkg::cal_t                 cal,
    input  wire logic [ccma_pkg::YMOD_BITS-1:0] ymod,
    output ccma_pkg::cal_t                      cal_next,
    output logic      [ccma_pkg::YMOD_BITS-1:0] ymod_next
);

    import ccma_pkg::*;

    logic                  leap;
    logic [DAY_BITS-1:0]   mlen;
    logic                  min_wrap;
    logic                  hour_wrap;
    logic [DAY_BITS:0]     day_inc;
    logic [MONTH_BITS:0]   month_inc;
    logic                  day_over;
    logic                  month_over;

    // leap when divisible by 4, except centuries not divisible by 400
    assign leap = (ymod[1:0] == 2'b00)
               && (ymod != YMOD_BITS'(CENTURY))
               && (ymod != YMOD_BITS'(2 * CENTURY))
               && (ymod != YMOD_BITS'(3 * CENTURY));
    assign mlen = month_length(cal.month, leap);

    assign min_wrap   = (cal.minute == MINUTE_BITS'(MINUTES_PER_HOUR - 1));
    assign hour_wrap  = (cal.hour == HOUR_BITS'(HOURS_PER_DAY - 1));
    assign day_inc    = {1'b0, cal.day} + (DAY_BITS+1)'(1);
    assign month_inc  = {1'b0, cal.month} + (MONTH_BITS+1)'(1);
    assign day_over   = (day_inc > {1'b0, mlen});
    assign month_over = (month_inc > (MONTH_BITS+1)'(MONTHS_PER_YEAR));

    always_comb
    begin
        cal_next  = cal;
        ymod_next = ymod;
        if (min_wrap)
        begin
            cal_next.minute = '0;
            if (hour_wrap)
            begin
                cal_next.hour = '0;
                if (day_over)
                begin
                    cal_next.day = DAY_BITS'(1);
                    if (month_over)
                    begin
                        cal_next.month = MONTH_JAN;
                        cal_next.year  = cal.year + YEAR_BITS'(1);
                        // the 16-bit year wrap is not a multiple of 400
                        if (cal.year == {YEAR_BITS{1'b1}} ||
                            ymod == YMOD_BITS'(YEAR_CYCLE - 1))
                        begin
                            ymod_next = '0;
                        end
                        else
                        begin
                            ymod_next = ymod + YMOD_BITS'(1);
                        end
                    end
                    else
                    begin
                        cal_next.month = month_inc[MONTH_BITS-1:0];
                    end
                end
                else
                begin
                    cal_next.day = day_inc[DAY_BITS-1:0];
                end
            end
            else
            begin
                cal_next.hour = cal.hour + HOUR_BITS'(1);
            end
        end
        else
        begin
            cal_next.minute = cal.minute + MINUTE_BITS'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccma_seq.sv =====
// sequencer for the calendar clock: drives the shared subtract unit
// depends on ccma_pkg
`default_nettype none

module ccma_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           command,
    input  wire logic           ge,
    input  wire logic           out_free,
    output ccma_pkg::ctrl_t     ctrl
);

    import ccma_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [SHIFT_BITS-1:0] shift_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        case (state_reg)
            ST_IDLE:
            begin
                shift_next = SHIFT_BITS'(YMOD_STEPS - 1);
                if (in_fire)
                begin
                    state_next = (command == CMD_SET) ? ST_YMOD : ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (!ge)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_YMOD:
            begin
                shift_next = shift_reg - SHIFT_BITS'(1);
                if (shift_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.shift    = shift_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_STEP:
            begin
                ctrl.step_en = ge;
            end
            ST_YMOD:
            begin
                ctrl.sel_year = 1'b1;
                ctrl.ymod_en  = ge;
            end
            ST_DONE:
            begin
                ctrl.load_out = out_free;
            end
            default:
            begin
                ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccma_checker.sv =====
// port-level checks for the calendar clock, bound to the top level
// depends on ccma_pkg and calendar_clock_minute_advance_unit_defines.svh
`default_nettype none
`include "calendar_clock_minute_advance_unit_defines.svh"

module ccma_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [ccma_pkg::YEAR_BITS-1:0]    year_now,
    input wire logic [ccma_pkg::HOUR_BITS-1:0]    hour_now,
    input wire logic [ccma_pkg::MINUTE_BITS-1:0]  minute_now
);

    import ccma_pkg::*;

    localparam logic [HOUR_BITS-1:0]   HOUR_END   = HOUR_BITS'(HOURS_PER_DAY);
    localparam logic [MINUTE_BITS-1:0] MINUTE_END = MINUTE_BITS'(MINUTES_PER_HOUR);

    // one request at a time: busy right after taking one
    `CCMA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // time of day always comes out normalized
    `CCMA_ASSERT_SAME(a_time_range, out_valid, (hour_now < HOUR_END) && (minute_now < MINUTE_END))

    // stalled result holds
    `CCMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(year_now) && $stable(minute_now))

endmodule

bind calendar_clock_minute_advance_unit ccma_checker u_ccma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .year_now   (year_now),
    .hour_now   (hour_now),
    .minute_now (minute_now)
);

`default_nettype wire
